>>> rtl/core/doc_pkg.sv
// Shared types and constants for the day occupancy calendar.
// Used by doc_table and by the top level day_occupancy_calendar.
package doc_pkg;

    localparam int DAY_W = 9;
    localparam int SUM_W = DAY_W + 1;
    localparam int OUT_W = 16;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_OCCUPY  = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_DAYOFF  = 3'd3;
    localparam logic [2:0] CMD_RMAX    = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    localparam logic REG_DAYS    = 1'b0;
    localparam logic REG_WEEKDAY = 1'b1;

    localparam logic [2:0] WEEK_LAST     = 3'd6;
    localparam logic [2:0] FIRST_WEEKEND = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } doc_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_OCCUPY,
        OP_RELEASE,
        OP_DAYOFF,
        OP_RMAX,
        OP_READ
    } walk_op_t;

    typedef struct packed {
        logic     issue;
        walk_op_t op;
        logic     init_blk;
        logic     clr_max;
    } walk_ctl_t;

endpackage

>>> rtl/core/doc_table.sv
// Day table memory with its read-modify-write unit and range maximum.
// One day entry is issued per cycle; read-modify-write updates are written back in the following cycle.
// Depends on doc_pkg.
module doc_table #(
    parameter int DAY_SLOTS  = 512,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  doc_pkg::walk_ctl_t            ctl,
    input  logic [$clog2(DAY_SLOTS)-1:0]  addr,
    output logic [COUNT_BITS-1:0]         max_count,
    output logic [COUNT_BITS-1:0]         rd_count,
    output logic                          rd_blocked
);
    import doc_pkg::*;

    localparam int SLOT_W  = $clog2(DAY_SLOTS);
    localparam int ENTRY_W = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] CNT_LIM = '1;

    logic [ENTRY_W-1:0]    day_mem [DAY_SLOTS];
    logic [ENTRY_W-1:0]    rd_q_reg;
    logic                  p_valid_reg;
    walk_op_t              p_op_reg;
    logic [SLOT_W-1:0]     p_addr_reg;
    logic [COUNT_BITS-1:0] max_reg;
    logic [COUNT_BITS-1:0] max_next;

    logic                  rd_en;
    logic                  s0_wr;
    logic                  s1_wr;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic                  q_blk;
    logic [COUNT_BITS-1:0] q_cnt;

    assign q_blk = rd_q_reg[COUNT_BITS];
    assign q_cnt = rd_q_reg[COUNT_BITS-1:0];

    always_comb
    begin
        rd_en = ctl.issue && (ctl.op == OP_OCCUPY || ctl.op == OP_RELEASE ||
                              ctl.op == OP_RMAX || ctl.op == OP_READ);
        s0_wr = ctl.issue && (ctl.op == OP_INIT || ctl.op == OP_DAYOFF);
        s1_wr = p_valid_reg && !q_blk &&
                ((p_op_reg == OP_OCCUPY && q_cnt != CNT_LIM) ||
                 (p_op_reg == OP_RELEASE && q_cnt != '0));
        wr_en = s0_wr || s1_wr;
        if (s0_wr)
        begin
            wr_addr = addr;
            wr_data = (ctl.op == OP_DAYOFF) ? {1'b1, {COUNT_BITS{1'b0}}}
                                            : {ctl.init_blk, {COUNT_BITS{1'b0}}};
        end
        else
        begin
            wr_addr = p_addr_reg;
            wr_data = (p_op_reg == OP_OCCUPY) ? {1'b0, q_cnt + 1'b1}
                                              : {1'b0, q_cnt - 1'b1};
        end
    end

    always_comb
    begin
        max_next = max_reg;
        if (ctl.clr_max)
        begin
            max_next = '0;
        end
        else if (p_valid_reg && p_op_reg == OP_RMAX && !q_blk && q_cnt > max_reg)
        begin
            max_next = q_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            day_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= day_mem[addr];
        end
        p_op_reg   <= ctl.op;
        p_addr_reg <= addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            max_reg     <= '0;
        end
        else
        begin
            p_valid_reg <= rd_en;
            max_reg     <= max_next;
        end
    end

    assign max_count  = max_reg;
    assign rd_count   = q_cnt;
    assign rd_blocked = q_blk;

    // issue-time writes and write-back never overlap within one command
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(s0_wr && s1_wr))
        else $error("doc_table: two writers in one cycle");

    a_read_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> p_valid_reg)
        else $error("doc_table: read not followed by write-back stage");

    a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.clr_max |=> (max_reg >= $past(max_reg)))
        else $error("doc_table: range maximum decreased");

endmodule

>>> rtl/core/day_occupancy_calendar.sv
// Day occupancy calendar: per-day blocked mark and saturating job count.
// An init command sweeps every table slot, a range command walks its days and a
// single-day command its one day; an invalid or empty one goes straight to its result.
// The next command is held off until the last is done and while its result is stalled.
// Reset: controller idle, no result pending, days_in_year 365, first_weekday 0;
// table contents undefined until the first init command.
module day_occupancy_calendar #(
    parameter int DAY_SLOTS  = 512,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [8:0]  start_day,
    input  logic [8:0]  span_days,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] max_count,
    output logic [15:0] day_jobs,
    output logic        day_blocked,
    output logic        range_clipped
);
    import doc_pkg::*;

    localparam int SLOT_W  = $clog2(DAY_SLOTS);
    localparam int RANGE_W = (SLOT_W > SUM_W) ? SLOT_W : SUM_W;
    localparam int SAT_W   = COUNT_BITS + OUT_W;
    localparam logic [RANGE_W-1:0] LAST_SLOT = RANGE_W'(DAY_SLOTS - 1);

    doc_state_t state_reg, state_next;

    logic [DAY_W-1:0]   days_in_year_reg;
    logic [2:0]         first_weekday_reg;

    logic [RANGE_W-1:0] cur_reg, cur_next;
    logic [RANGE_W-1:0] hi_reg, hi_next;
    logic [2:0]         wd_reg, wd_next;
    walk_op_t           op_reg, op_next;
    logic               clip_reg, clip_next;

    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   max_count_reg, max_count_next;
    logic [OUT_W-1:0]   day_jobs_reg, day_jobs_next;
    logic               day_blocked_reg, day_blocked_next;
    logic               range_clipped_reg, range_clipped_next;

    logic               in_fire;
    logic               cfg_wr;
    logic               out_load;

    // command decode
    logic [RANGE_W-1:0] start_w, hi_raw, end_w, lo_w, hi_eff;
    logic               range_clip, day_bad;
    walk_op_t           dec_op;
    logic [RANGE_W-1:0] dec_cur, dec_hi;
    logic               dec_clip, dec_walk, dec_init;

    walk_ctl_t             tab_ctl;
    logic [COUNT_BITS-1:0] tab_max, tab_count;
    logic                  tab_blocked;
    logic [SAT_W-1:0]      max_wide, cnt_wide;
    logic [OUT_W-1:0]      max_sat, cnt_sat;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        if (paddr[2] == REG_WEEKDAY)
        begin
            prdata = {29'd0, first_weekday_reg};
        end
        else
        begin
            prdata = {23'd0, days_in_year_reg};
        end
    end

    always_comb
    begin
        start_w    = RANGE_W'(start_day);
        hi_raw     = start_w + RANGE_W'(span_days);
        end_w      = (RANGE_W'(days_in_year_reg) > LAST_SLOT) ? LAST_SLOT
                                                              : RANGE_W'(days_in_year_reg);
        lo_w       = (start_day == '0) ? RANGE_W'(1) : start_w;
        range_clip = hi_raw > end_w;
        hi_eff     = range_clip ? end_w : hi_raw;
        day_bad    = (start_day == '0) || (start_w > end_w);

        dec_op   = OP_NONE;
        dec_cur  = lo_w;
        dec_hi   = hi_eff;
        dec_clip = 1'b0;
        dec_walk = 1'b0;
        dec_init = 1'b0;
        case (command)
            CMD_INIT:
            begin
                dec_op   = OP_INIT;
                dec_cur  = '0;
                dec_hi   = LAST_SLOT;
                dec_init = 1'b1;
            end
            CMD_OCCUPY, CMD_RELEASE, CMD_RMAX:
            begin
                dec_op   = (command == CMD_OCCUPY)  ? OP_OCCUPY :
                           (command == CMD_RELEASE) ? OP_RELEASE : OP_RMAX;
                dec_clip = range_clip;
                dec_walk = (lo_w <= hi_eff);
            end
            CMD_DAYOFF, CMD_READ:
            begin
                dec_cur  = start_w;
                dec_hi   = start_w;
                dec_clip = day_bad;
                dec_walk = !day_bad;
                if (!day_bad)
                begin
                    dec_op = (command == CMD_DAYOFF) ? OP_DAYOFF : OP_READ;
                end
            end
            default:
            begin
                dec_op = OP_NONE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = dec_init ? ST_INIT : (dec_walk ? ST_WALK : ST_DONE);
                end
            end
            ST_INIT:
            begin
                if (cur_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_WALK:
            begin
                if (cur_reg == hi_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        tab_ctl.issue    = (state_reg == ST_INIT) || (state_reg == ST_WALK);
        tab_ctl.op       = op_reg;
        tab_ctl.init_blk = (cur_reg != '0) && (cur_reg <= end_w) && (wd_reg >= FIRST_WEEKEND);
        tab_ctl.clr_max  = in_fire;
        out_load         = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        cur_next  = cur_reg;
        hi_next   = hi_reg;
        wd_next   = wd_reg;
        op_next   = op_reg;
        clip_next = clip_reg;
        if (in_fire)
        begin
            cur_next  = dec_cur;
            hi_next   = dec_hi;
            op_next   = dec_op;
            clip_next = dec_clip;
            wd_next   = (first_weekday_reg > WEEK_LAST) ? 3'd0 : first_weekday_reg;
        end
        else if (tab_ctl.issue)
        begin
            cur_next = cur_reg + 1'b1;
            if (state_reg == ST_INIT && cur_reg != '0)
            begin
                wd_next = (wd_reg == WEEK_LAST) ? 3'd0 : wd_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        max_wide = SAT_W'(tab_max);
        cnt_wide = SAT_W'(tab_count);
        max_sat  = (max_wide > SAT_W'(OUT_MAX)) ? OUT_MAX : max_wide[OUT_W-1:0];
        cnt_sat  = (cnt_wide > SAT_W'(OUT_MAX)) ? OUT_MAX : cnt_wide[OUT_W-1:0];

        out_valid_next     = out_valid_reg && out_stall;
        max_count_next     = max_count_reg;
        day_jobs_next      = day_jobs_reg;
        day_blocked_next   = day_blocked_reg;
        range_clipped_next = range_clipped_reg;
        if (out_load)
        begin
            out_valid_next     = 1'b1;
            max_count_next     = (op_reg == OP_RMAX) ? max_sat : '0;
            day_jobs_next      = (op_reg == OP_READ) ? cnt_sat : '0;
            day_blocked_next   = (op_reg == OP_READ) && tab_blocked;
            range_clipped_next = clip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            days_in_year_reg  <= DAY_W'(365);
            first_weekday_reg <= 3'd0;
            cur_reg           <= '0;
            hi_reg            <= '0;
            wd_reg            <= 3'd0;
            op_reg            <= OP_NONE;
            clip_reg          <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            hi_reg        <= hi_next;
            wd_reg        <= wd_next;
            op_reg        <= op_next;
            clip_reg      <= clip_next;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_DAYS)
                begin
                    days_in_year_reg <= pwdata[DAY_W-1:0];
                end
                else
                begin
                    first_weekday_reg <= pwdata[2:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        max_count_reg     <= max_count_next;
        day_jobs_reg      <= day_jobs_next;
        day_blocked_reg   <= day_blocked_next;
        range_clipped_reg <= range_clipped_next;
    end

    doc_table #(
        .DAY_SLOTS  (DAY_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tab_ctl),
        .addr       (cur_reg[SLOT_W-1:0]),
        .max_count  (tab_max),
        .rd_count   (tab_count),
        .rd_blocked (tab_blocked)
    );

    assign out_valid     = out_valid_reg;
    assign max_count     = max_count_reg;
    assign day_jobs      = day_jobs_reg;
    assign day_blocked   = day_blocked_reg;
    assign range_clipped = range_clipped_reg;

    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cur_reg <= hi_reg && hi_reg <= LAST_SLOT))
        else $error("walk address out of range");

    a_init_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (cur_reg <= LAST_SLOT))
        else $error("init sweep past last slot");

    // a finished result waits while the previous one is still stalled
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> (state_reg == ST_DONE))
        else $error("result overwrote a pending transfer");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(max_count_reg)))
        else $error("stalled result changed");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for day_occupancy_calendar: a day table kept in step
// with the block predicts every result. Depends on doc_pkg and the block's RTL only.
module tb;
    import doc_pkg::*;

    localparam int SLOTS = 512;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 600;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam logic [8:0] YEAR_SHORT = 9'd365;
    localparam logic [8:0] YEAR_LEAP = 9'd366;

    typedef struct packed {
        logic [15:0] max_count;
        logic [15:0] day_jobs;
        logic        day_blocked;
        logic        range_clipped;
    } day_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [8:0]  start_day;
    logic [8:0]  span_days;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] max_count;
    logic [15:0] day_jobs;
    logic        day_blocked;
    logic        range_clipped;

    // calendar as the block should hold it
    logic        cal_blocked [SLOTS];
    logic [15:0] cal_jobs [SLOTS];
    logic [8:0]  cfg_days;
    logic [2:0]  cfg_weekday;

    day_result_t pending_results[$];
    int          mismatches;
    int          cycles;
    int          burst_left;
    int          stall_hold;
    int          stall_mode;

    day_occupancy_calendar dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .start_day(start_day),
        .span_days(span_days),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .max_count(max_count),
        .day_jobs(day_jobs),
        .day_blocked(day_blocked),
        .range_clipped(range_clipped)
    );

    // low phase first so no rising edge falls at time zero
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic day_result_t apply_cmd(logic [2:0] c, logic [8:0] s, logic [8:0] n);
        day_result_t r;
        int last;
        int lo;
        int hi;
        int d;
        int wd;
        r = '0;
        last = (cfg_days > SLOTS - 1) ? SLOTS - 1 : cfg_days;
        case (c)
            CMD_INIT:
            begin
                wd = (cfg_weekday > WEEK_LAST) ? 0 : cfg_weekday;
                for (d = 0; d < SLOTS; d++)
                begin
                    cal_jobs[d] = '0;
                    cal_blocked[d] = 1'b0;
                end
                for (d = 1; d <= last; d++)
                begin
                    cal_blocked[d] = (wd >= FIRST_WEEKEND);
                    wd = (wd == WEEK_LAST) ? 0 : wd + 1;
                end
            end
            CMD_DAYOFF, CMD_READ:
            begin
                if (s == 0 || s > last)
                    r.range_clipped = 1'b1;
                else if (c == CMD_DAYOFF)
                begin
                    cal_blocked[s] = 1'b1;
                    cal_jobs[s] = '0;
                end
                else
                begin
                    r.day_jobs = cal_jobs[s];
                    r.day_blocked = cal_blocked[s];
                end
            end
            CMD_OCCUPY, CMD_RELEASE, CMD_RMAX:
            begin
                lo = (s == 0) ? 1 : s;
                hi = s + n;
                if (hi > last)
                begin
                    hi = last;
                    r.range_clipped = 1'b1;
                end
                for (d = lo; d <= hi && d < SLOTS; d++)
                begin
                    if (!cal_blocked[d])
                    begin
                        if (c == CMD_OCCUPY && cal_jobs[d] != OUT_MAX)
                            cal_jobs[d] = cal_jobs[d] + 1'b1;
                        else if (c == CMD_RELEASE && cal_jobs[d] != 0)
                            cal_jobs[d] = cal_jobs[d] - 1'b1;
                        else if (c == CMD_RMAX && cal_jobs[d] > r.max_count)
                            r.max_count = cal_jobs[d];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // one command transfer; the sender sometimes idles between bursts of random length
    task automatic send_cmd(logic [2:0] c, logic [8:0] s, logic [8:0] n);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= c;
        start_day <= s;
        span_days <= n;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_cmd(c, s, n));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_DAYS)
            cfg_days = value[8:0];
        else
            cfg_weekday = value[2:0];
    endtask

    // read transfer; the register must come back as written
    task automatic read_check(logic reg_sel, logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata != want || !pready)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch prdata: expected %0d, got %0d", want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_year(logic [8:0] days, logic [2:0] weekday);
        wait_idle();
        write_reg(REG_DAYS, {23'd0, days});
        write_reg(REG_WEEKDAY, {29'd0, weekday});
        read_check(REG_DAYS, {23'd0, days});
        read_check(REG_WEEKDAY, {29'd0, weekday});
    endtask

    task automatic send_random_cmd();
        int pick;
        logic [2:0] c;
        logic [8:0] s;
        logic [8:0] n;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            c = CMD_OCCUPY;
        else if (pick < 45)
            c = CMD_RELEASE;
        else if (pick < 65)
            c = CMD_RMAX;
        else if (pick < 85)
            c = CMD_READ;
        else if (pick < 93)
            c = CMD_DAYOFF;
        else if (pick < 96)
            c = CMD_INIT;
        else
            c = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            s = 9'd0;
        else if (pick < 20)
            s = 9'($urandom_range(360, 368));
        else if (pick < 28)
            s = 9'($urandom_range(367, 511));
        else
            s = 9'($urandom_range(1, 366));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            n = 9'($urandom_range(0, 15));
        else if (pick < 90)
            n = 9'($urandom_range(0, 365));
        else
            n = 9'($urandom_range(0, 511));
        send_cmd(c, s, n);
    endtask

    // edges of every command on the reset year: Monday first, 365 days
    task automatic test_directed();
        send_cmd(CMD_INIT, 9'd0, 9'd0);
        send_cmd(CMD_READ, 9'd1, 9'd0);
        send_cmd(CMD_READ, 9'd6, 9'd0);
        send_cmd(CMD_READ, 9'd0, 9'd0);
        send_cmd(CMD_READ, 9'd366, 9'd0);
        send_cmd(CMD_READ, 9'd511, 9'd511);
        send_cmd(CMD_OCCUPY, 9'd0, 9'd511);
        send_cmd(CMD_OCCUPY, 9'd1, 9'd0);
        send_cmd(CMD_RMAX, 9'd0, 9'd511);
        send_cmd(CMD_RMAX, 9'd6, 9'd1);
        send_cmd(CMD_RELEASE, 9'd1, 9'd4);
        send_cmd(CMD_RELEASE, 9'd2, 9'd2);
        send_cmd(CMD_RMAX, 9'd1, 9'd4);
        send_cmd(CMD_DAYOFF, 9'd1, 9'd0);
        send_cmd(CMD_READ, 9'd1, 9'd0);
        send_cmd(CMD_RMAX, 9'd1, 9'd0);
        send_cmd(CMD_DAYOFF, 9'd0, 9'd0);
        send_cmd(CMD_DAYOFF, 9'd366, 9'd0);
        send_cmd(CMD_RMAX, 9'd400, 9'd0);
        send_cmd(CMD_RMAX, 9'd365, 9'd0);
        send_cmd(CMD_OCCUPY, 9'd365, 9'd1);
        send_cmd(CMD_SPARE6, 9'd511, 9'd511);
        send_cmd(CMD_SPARE7, 9'd3, 9'd3);
        send_cmd(CMD_READ, 9'd365, 9'd0);
    endtask

    // weekend layout for every first weekday, including the out-of-range code
    task automatic test_year_layout();
        int wd;
        int d;
        for (wd = 0; wd <= 7; wd++)
        begin
            set_year((wd % 2) ? YEAR_LEAP : YEAR_SHORT, wd[2:0]);
            send_cmd(CMD_INIT, 9'd0, 9'd0);
            for (d = 1; d <= 7; d++)
                send_cmd(CMD_READ, d[8:0], 9'd0);
            send_cmd(CMD_READ, YEAR_LEAP, 9'd0);
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int i;
        for (phase = 0; phase < 8; phase++)
        begin
            set_year((phase % 2) ? YEAR_LEAP : YEAR_SHORT, 3'($urandom_range(0, 7)));
            send_cmd(CMD_INIT, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
            for (i = 0; i < 192; i++)
                send_random_cmd();
        end
    endtask

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        day_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result transfer with nothing outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("max_count", want.max_count, max_count);
                check_field("day_jobs", want.day_jobs, day_jobs);
                check_field("day_blocked", want.day_blocked, day_blocked);
                check_field("range_clipped", want.range_clipped, range_clipped);
            end
        end
    end

    // receiver: switches between no stall, random stall and a periodic pattern
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(50, 400);
        end
        else
            stall_hold <= stall_hold - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= (cycles % 8 >= 5);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        command <= CMD_INIT;
        start_day <= '0;
        span_days <= '0;
        out_stall <= 1'b0;
        cfg_days = YEAR_SHORT;
        cfg_weekday = 3'd0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        stall_hold = 0;
        stall_mode = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_year_layout();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/doc_pkg.sv
rtl/core/doc_table.sv
rtl/core/day_occupancy_calendar.sv
tb/tb.sv
